// ===== src/stun_map_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN mapped-port extractor package
// Shared constants, result codes and the result type used between modules.
// ----------------------------------------------------------------------------
package stun_map_pkg;

    // Longest datagram that is parsed; later bytes are dropped.
    localparam int MAX_BYTES = 1024;
    localparam int OFFSET_W  = $clog2(MAX_BYTES + 1);

    // Attribute lengths and offsets are compared in this width, which holds a
    // padded 16-bit length plus the attribute header.
    localparam int SPAN_W = 18;

    localparam int HEADER_BYTES = 20;

    localparam logic [15:0] BIND_RESP_TYPE       = 16'h0101;
    localparam logic [15:0] ATTR_MAPPED_ADDR     = 16'h0001;
    localparam logic [15:0] ATTR_XOR_MAPPED_ADDR = 16'h0020;
    localparam logic [15:0] MAGIC_COOKIE_HI      = 16'h2112;

    // Attribute header length and the offset of the port within the attribute.
    localparam int ATTR_HDR_BYTES = 4;
    localparam int PORT_OFFSET    = 6;

    typedef enum logic [2:0] {
        ST_MAPPED     = 3'd0,
        ST_XMAPPED    = 3'd1,
        ST_SHORT      = 3'd2,
        ST_WRONG_TYPE = 3'd3,
        ST_BAD_LEN    = 3'd4,
        ST_NONE       = 3'd5,
        ST_UNDECIDED  = 3'd7
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] mapped_port;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } result_beat_t;

endpackage

// ===== src/stun_map_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN mapped-port extractor channels
// Valid/ready channels for datagram bytes in and parse results out.
// ----------------------------------------------------------------------------
interface stun_map_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface stun_map_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] mapped_port;

    modport source (output valid, output status, output mapped_port, input ready);
    modport sink   (input valid, input status, input mapped_port, output ready);
endinterface

// ===== src/stun_map_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN mapped-port extractor byte parser
// Walks header and attributes one byte per cycle while the output buffer has space, and forms the result.
// ----------------------------------------------------------------------------
module stun_map_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    stun_map_in_if.sink                datagram,
    input  logic                       space_ok,
    output stun_map_pkg::result_beat_t beat
);
    import stun_map_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ATTR,
        PH_CAND,
        PH_DONE
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic [OFFSET_W-1:0] offset_reg,  offset_next;
    logic [15:0]         type_reg,    type_next;
    logic [OFFSET_W-1:0] idx_reg,     idx_next;
    logic [15:0]         kind_reg,    kind_next;
    logic [15:0]         len_reg,     len_next;
    logic [15:0]         port_reg,    port_next;
    status_t             verdict_reg, verdict_next;
    logic [OFFSET_W-1:0] cand_reg,    cand_next;

    logic accept;
    logic active;

    assign datagram.ready = space_ok;
    assign accept         = datagram.valid && space_ok;
    assign active         = offset_reg < OFFSET_W'(MAX_BYTES);

    always_comb
    begin
        logic [SPAN_W-1:0] walk_end;
        logic [SPAN_W-1:0] value_end;
        logic [SPAN_W-1:0] idx_ext;
        logic              is_mapped;

        phase_next   = phase_reg;
        offset_next  = offset_reg;
        type_next    = type_reg;
        idx_next     = idx_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        port_next    = port_reg;
        verdict_next = verdict_reg;
        cand_next    = cand_reg;
        walk_end     = '0;
        is_mapped    = (kind_reg == ATTR_MAPPED_ADDR) ||
                       (kind_reg == ATTR_XOR_MAPPED_ADDR);
        beat.valid           = 1'b0;
        beat.res.status      = ST_NONE;
        beat.res.mapped_port = '0;

        if (accept && active)
        begin
            offset_next = offset_reg + 1'b1;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == '0)
                        type_next = {datagram.data_byte, 8'h00};
                    else if (offset_reg == OFFSET_W'(1))
                        type_next = {type_reg[15:8], datagram.data_byte};
                    if (offset_reg == OFFSET_W'(HEADER_BYTES - 1))
                    begin
                        if (type_reg != BIND_RESP_TYPE)
                        begin
                            verdict_next = ST_WRONG_TYPE;
                            phase_next   = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_ATTR;
                            idx_next   = '0;
                        end
                    end
                end
                PH_ATTR:
                begin
                    idx_next = idx_reg + 1'b1;
                    case (idx_reg)
                        OFFSET_W'(0): kind_next = {datagram.data_byte, 8'h00};
                        OFFSET_W'(1): kind_next = {kind_reg[15:8], datagram.data_byte};
                        OFFSET_W'(2): len_next  = {datagram.data_byte, 8'h00};
                        OFFSET_W'(3):
                        begin
                            len_next = {len_reg[15:8], datagram.data_byte};
                            if (is_mapped)
                            begin
                                if (len_next < 16'(ATTR_HDR_BYTES))
                                begin
                                    verdict_next = ST_BAD_LEN;
                                    phase_next   = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_CAND;
                                    cand_next  = OFFSET_W'(ATTR_HDR_BYTES);
                                end
                            end
                        end
                        default: ;
                    endcase
                    // Skip to the next attribute once the padded value is consumed.
                    walk_end = ((SPAN_W'(len_next) + SPAN_W'(3)) & ~SPAN_W'(3)) +
                               SPAN_W'(ATTR_HDR_BYTES);
                    if ((phase_next == PH_ATTR) &&
                        (idx_next >= OFFSET_W'(ATTR_HDR_BYTES)) &&
                        (SPAN_W'(idx_next) >= walk_end))
                        idx_next = '0;
                end
                PH_CAND:
                begin
                    if (idx_reg == OFFSET_W'(PORT_OFFSET))
                        port_next = {datagram.data_byte, port_reg[7:0]};
                    else if (idx_reg == OFFSET_W'(PORT_OFFSET + 1))
                        port_next = {port_reg[15:8], datagram.data_byte};
                    if (idx_reg < OFFSET_W'(PORT_OFFSET + 2))
                        idx_next = idx_reg + 1'b1;
                    cand_next = cand_reg + 1'b1;
                end
                PH_DONE: ;
                default: ;
            endcase
        end

        value_end = SPAN_W'(len_next) + SPAN_W'(ATTR_HDR_BYTES);
        idx_ext   = SPAN_W'(idx_next);

        if (accept && datagram.end_of_datagram)
        begin
            beat.valid = 1'b1;
            if (offset_next < OFFSET_W'(HEADER_BYTES))
                beat.res.status = ST_SHORT;
            else if (verdict_next != ST_UNDECIDED)
                beat.res.status = verdict_next;
            else if (phase_next == PH_CAND)
            begin
                if (SPAN_W'(cand_next) >= value_end)
                begin
                    if (kind_next == ATTR_XOR_MAPPED_ADDR)
                    begin
                        beat.res.status      = ST_XMAPPED;
                        beat.res.mapped_port = port_next ^ MAGIC_COOKIE_HI;
                    end
                    else
                    begin
                        beat.res.status      = ST_MAPPED;
                        beat.res.mapped_port = port_next;
                    end
                end
                else
                    beat.res.status = ST_BAD_LEN;
            end
            else if (phase_next == PH_ATTR)
            begin
                if (idx_next == '0)
                    beat.res.status = ST_NONE;
                else if (idx_ext < value_end)
                    beat.res.status = ST_BAD_LEN;
                else
                    beat.res.status = ST_NONE;
            end

            // Back to the idle state for the next datagram.
            phase_next   = PH_HEADER;
            offset_next  = '0;
            type_next    = '0;
            idx_next     = '0;
            kind_next    = '0;
            len_next     = '0;
            port_next    = '0;
            verdict_next = ST_UNDECIDED;
            cand_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            offset_reg  <= '0;
            type_reg    <= '0;
            idx_reg     <= '0;
            kind_reg    <= '0;
            len_reg     <= '0;
            port_reg    <= '0;
            verdict_reg <= ST_UNDECIDED;
            cand_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            type_reg    <= type_next;
            idx_reg     <= idx_next;
            kind_reg    <= kind_next;
            len_reg     <= len_next;
            port_reg    <= port_next;
            verdict_reg <= verdict_next;
            cand_reg    <= cand_next;
        end
    end

endmodule

// ===== src/stun_map_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN mapped-port extractor result buffer
// Output register with a skid entry so the parser keeps running under stall until the skid entry is full.
// ----------------------------------------------------------------------------
module stun_map_outbuf
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  stun_map_pkg::result_beat_t beat,
    output logic                       space_ok,
    stun_map_out_if.source             result
);
    import stun_map_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign space_ok           = !skid_valid_reg;
    assign result.valid       = main_valid_reg;
    assign result.status      = main_reg.status;
    assign result.mapped_port = main_reg.mapped_port;
    assign pop                = main_valid_reg && result.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = beat.valid;
                main_next       = beat.res;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = beat.valid;
            main_next       = beat.res;
        end
        else if (beat.valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = beat.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== src/stun_mapped_port_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN mapped-port extractor
// Parses a STUN binding response byte by byte and reports the mapped port.
// ----------------------------------------------------------------------------
// Usage: the datagram channel carries one byte of a received datagram per
// item, with end_of_datagram set on its final byte. Each item is parsed in
// the cycle it is accepted, so a new byte can be taken in every cycle while
// the result buffer has room; the rate is then one item per cycle.
// Only the final byte of a datagram produces an item on the result channel:
// a status code and, for a MAPPED-ADDRESS or XOR-MAPPED-ADDRESS hit, the
// port. The result is registered in the output buffer before it appears.
// Bytes beyond the first MAX_BYTES of a datagram are accepted and dropped,
// but their end flag still produces a result.
// When the receiver stalls, results wait in the output register and one
// further result can be held in a skid entry; only when both are full is
// datagram ready taken low. Until then, parsing continues.
// Reset returns the parser to the start of a datagram and empties the
// result buffer; no clearing pass is needed and the block is ready at once.
// ----------------------------------------------------------------------------
module stun_mapped_port_extractor
(
    input  logic           clk,
    input  logic           rst_n,
    stun_map_in_if.sink    datagram,
    stun_map_out_if.source result
);
    import stun_map_pkg::*;

    // Result of the final byte, handed from the parser to the output buffer.
    result_beat_t beat;
    // High while the output buffer can take one more result.
    logic         space_ok;

    stun_map_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .datagram (datagram),
        .space_ok (space_ok),
        .beat     (beat)
    );

    stun_map_outbuf u_outbuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .space_ok (space_ok),
        .result   (result)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN mapped-port extractor testbench
// Streams STUN datagrams into the extractor one byte per item, with random
// gaps on the byte channel and random stalls on the result channel, and
// checks every result against a byte-level parser kept in the scoreboard.
// ----------------------------------------------------------------------------
import stun_map_pkg::*;

typedef enum {PARSE_HEADER, PARSE_ATTR, PARSE_PORT, PARSE_DONE} parse_phase_t;

typedef struct {
    status_t     status;
    bit [15:0]   port;
} port_result_t;

class mapped_port_scoreboard;

    bit [OFFSET_W-1:0] bytes_seen;
    bit [15:0]         msg_type;
    parse_phase_t      phase;
    bit [SPAN_W-1:0]   attr_pos;
    bit [15:0]         attr_code;
    bit [15:0]         attr_len;
    bit [15:0]         port_bytes;
    bit [SPAN_W-1:0]   port_attr_bytes;
    status_t           early_status;

    port_result_t      pending_results[$];
    int                failures;

    function new();
        failures = 0;
        restart();
    endfunction

    function void restart();
        bytes_seen      = '0;
        msg_type        = '0;
        phase           = PARSE_HEADER;
        attr_pos        = '0;
        attr_code       = '0;
        attr_len        = '0;
        port_bytes      = '0;
        port_attr_bytes = '0;
        early_status    = ST_UNDECIDED;
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    // Advances the parser by one accepted byte and, on the final byte of a
    // datagram, queues the result the block must produce.
    function void note_byte(bit [7:0] b, bit last);
        bit              was_port;
        bit [SPAN_W-1:0] padded;
        port_result_t    res;
        if (bytes_seen < MAX_BYTES)
        begin
            was_port = (phase == PARSE_PORT);
            case (phase)
                PARSE_HEADER:
                begin
                    if (bytes_seen == 0)
                        msg_type = {b, 8'h00};
                    else if (bytes_seen == 1)
                        msg_type[7:0] = b;
                    if (bytes_seen == HEADER_BYTES - 1)
                    begin
                        if (msg_type != BIND_RESP_TYPE)
                        begin
                            early_status = ST_WRONG_TYPE;
                            phase        = PARSE_DONE;
                        end
                        else
                        begin
                            phase    = PARSE_ATTR;
                            attr_pos = '0;
                        end
                    end
                end
                PARSE_ATTR:
                begin
                    case (attr_pos)
                        0: attr_code = {b, 8'h00};
                        1: attr_code[7:0] = b;
                        2: attr_len = {b, 8'h00};
                        3:
                        begin
                            attr_len[7:0] = b;
                            if (attr_code == ATTR_MAPPED_ADDR ||
                                attr_code == ATTR_XOR_MAPPED_ADDR)
                            begin
                                if (attr_len < 4)
                                begin
                                    early_status = ST_BAD_LEN;
                                    phase        = PARSE_DONE;
                                end
                                else
                                    phase = PARSE_PORT;
                            end
                        end
                        default: ;
                    endcase
                    attr_pos = attr_pos + 1'b1;
                    if (phase == PARSE_ATTR && attr_pos >= ATTR_HDR_BYTES)
                    begin
                        padded      = SPAN_W'(attr_len) + SPAN_W'(3);
                        padded[1:0] = 2'b00;
                        if (attr_pos >= ATTR_HDR_BYTES + padded)
                            attr_pos = '0;
                    end
                end
                PARSE_PORT:
                begin
                    if (attr_pos == PORT_OFFSET)
                        port_bytes[15:8] = b;
                    else if (attr_pos == PORT_OFFSET + 1)
                        port_bytes[7:0] = b;
                    if (attr_pos < PORT_OFFSET + 2)
                        attr_pos = attr_pos + 1'b1;
                end
                default: ;
            endcase
            if (phase == PARSE_PORT)
                port_attr_bytes = was_port ? port_attr_bytes + 1'b1
                                           : SPAN_W'(ATTR_HDR_BYTES);
            bytes_seen = bytes_seen + 1'b1;
        end
        if (!last)
            return;

        res.port = '0;
        if (bytes_seen < HEADER_BYTES)
            res.status = ST_SHORT;
        else if (early_status != ST_UNDECIDED)
            res.status = early_status;
        else if (phase == PARSE_PORT)
        begin
            // The candidate counts only if its unpadded value fits.
            if (port_attr_bytes >= ATTR_HDR_BYTES + attr_len)
            begin
                if (attr_code == ATTR_XOR_MAPPED_ADDR)
                begin
                    res.status = ST_XMAPPED;
                    res.port   = port_bytes ^ MAGIC_COOKIE_HI;
                end
                else
                begin
                    res.status = ST_MAPPED;
                    res.port   = port_bytes;
                end
            end
            else
                res.status = ST_BAD_LEN;
        end
        else if (phase == PARSE_ATTR && attr_pos != 0 &&
                 attr_pos < ATTR_HDR_BYTES + attr_len)
            res.status = ST_BAD_LEN;
        else
            res.status = ST_NONE;
        pending_results.push_back(res);
        restart();
    endfunction

    function void check_result(logic [2:0] status, logic [15:0] port);
        port_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result status %0d port %h arrived with none expected",
                     $time, status, port);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status)
        begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            failures++;
        end
        if (port !== want.port)
        begin
            $display("%0t: mapped_port expected %h, got %h", $time, want.port, port);
            failures++;
        end
    endfunction

endclass

module tb;

    // An attribute type the parser has no interest in, used as filler.
    localparam logic [15:0] OTHER_ATTR   = 16'h8022;
    localparam logic [15:0] COOKIE_TAIL  = 16'hA442;
    localparam logic [7:0]  FAMILY_IPV4  = 8'h01;
    // Lengths above this are declared but backed by only eight value bytes.
    localparam int          LONGEST_BODY = 1000;
    localparam int          RANDOM_BYTES = 300;
    localparam int          RANDOM_DGRAMS = 12;

    logic clk;
    logic rst_n;

    stun_map_in_if  in_ch();
    stun_map_out_if out_ch();

    stun_mapped_port_extractor u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .datagram (in_ch),
        .result   (out_ch)
    );

    mapped_port_scoreboard port_board = new();

    // The datagram being assembled, and the calm flags that switch off
    // idling for a whole datagram on the byte side and for one item on the result side.
    bit [7:0]    dgram_bytes[$];
    bit          src_calm;
    bit          snk_calm;
    int unsigned bytes_sent;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned idle_cycles(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Header: message type, a random length field, the magic cookie and a
    // random transaction ID. Only the type matters to the parser.
    function automatic void put_header(bit [15:0] msg);
        dgram_bytes.push_back(msg[15:8]);
        dgram_bytes.push_back(msg[7:0]);
        dgram_bytes.push_back(8'($urandom));
        dgram_bytes.push_back(8'($urandom));
        dgram_bytes.push_back(MAGIC_COOKIE_HI[15:8]);
        dgram_bytes.push_back(MAGIC_COOKIE_HI[7:0]);
        dgram_bytes.push_back(COOKIE_TAIL[15:8]);
        dgram_bytes.push_back(COOKIE_TAIL[7:0]);
        repeat (HEADER_BYTES - 8)
            dgram_bytes.push_back(8'($urandom));
    endfunction

    // One attribute with its value padded to four bytes. Mapped kinds carry
    // the port in value bytes 2 and 3. A huge declared length is followed by
    // only a few value bytes, so the datagram ends inside the value.
    function automatic void put_attr(bit [15:0] kind, bit [15:0] len, bit [15:0] port);
        int body;
        int i;
        body = (len > LONGEST_BODY) ? 8 : ((len + 3) / 4) * 4;
        dgram_bytes.push_back(kind[15:8]);
        dgram_bytes.push_back(kind[7:0]);
        dgram_bytes.push_back(len[15:8]);
        dgram_bytes.push_back(len[7:0]);
        for (i = 0; i < body; i++)
        begin
            if (i == 1)
                dgram_bytes.push_back(FAMILY_IPV4);
            else if (i == 2)
                dgram_bytes.push_back(port[15:8]);
            else if (i == 3)
                dgram_bytes.push_back(port[7:0]);
            else
                dgram_bytes.push_back(8'($urandom));
        end
    endfunction

    function automatic void truncate_to(int n);
        while (dgram_bytes.size() > n)
            void'(dgram_bytes.pop_back());
    endfunction

    // Offers one byte from a falling edge and returns at the falling edge
    // after it was taken. Valid stays high straight into the next item when
    // no gap is drawn.
    task automatic send_byte(input bit [7:0] b, input bit last);
        int unsigned gap;
        gap = idle_cycles(src_calm);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= b;
        in_ch.end_of_datagram <= last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        port_board.note_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_datagram();
        int i;
        src_calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < dgram_bytes.size(); i++)
            send_byte(dgram_bytes[i], i == dgram_bytes.size() - 1);
        dgram_bytes.delete();
    endtask

    // Hand-picked datagrams: every status, both port extremes, attribute
    // padding, truncation at each point of an attribute and overlong input.
    task automatic directed_datagrams();
        // A lone final byte, and a header one byte short.
        dgram_bytes.push_back(8'hFF);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        truncate_to(HEADER_BYTES - 1);
        send_datagram();

        // Wrong message types, the second with a valid attribute behind it.
        put_header(ATTR_MAPPED_ADDR);
        send_datagram();
        put_header(16'hFFFF);
        put_attr(ATTR_MAPPED_ADDR, 8, 16'h1234);
        send_datagram();

        // Empty attribute section.
        put_header(BIND_RESP_TYPE);
        send_datagram();

        // Port extremes, plain and XORed, and the shortest value with a port.
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 8, 16'hFFFF);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_XOR_MAPPED_ADDR, 8, 16'h0000);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 4, 16'h8001);
        send_datagram();

        // A padded filler attribute is skipped; the first mapped kind wins.
        put_header(BIND_RESP_TYPE);
        put_attr(OTHER_ATTR, 5, 16'h0000);
        put_attr(ATTR_XOR_MAPPED_ADDR, 20, 16'h7FFE);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 8, 16'h0102);
        put_attr(ATTR_XOR_MAPPED_ADDR, 8, 16'h0304);
        send_datagram();

        // Mapped values too short to hold a port.
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_XOR_MAPPED_ADDR, 3, 16'h0000);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 0, 16'h0000);
        put_attr(ATTR_MAPPED_ADDR, 8, 16'h5555);
        send_datagram();

        // Datagram ends inside a mapped value, inside an attribute header,
        // inside a filler value, inside its padding and right after its value.
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 8, 16'hABCD);
        truncate_to(HEADER_BYTES + 10);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(OTHER_ATTR, 8, 16'h0000);
        truncate_to(HEADER_BYTES + 2);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(OTHER_ATTR, 5, 16'h0000);
        truncate_to(HEADER_BYTES + 7);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(OTHER_ATTR, 5, 16'h0000);
        truncate_to(HEADER_BYTES + 10);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(OTHER_ATTR, 5, 16'h0000);
        truncate_to(HEADER_BYTES + 9);
        send_datagram();

        // A mapped value that ends exactly, without its padding, counts; one
        // with the largest declared length never fits.
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 5, 16'h4242);
        truncate_to(HEADER_BYTES + 9);
        send_datagram();
        put_header(BIND_RESP_TYPE);
        put_attr(ATTR_MAPPED_ADDR, 16'hFFFF, 16'h4242);
        send_datagram();

        // Overlong datagram: an XOR-mapped attribute that ends on the last
        // parsed byte, followed by bytes that are dropped.
        put_header(BIND_RESP_TYPE);
        put_attr(OTHER_ATTR, 16'(MAX_BYTES - HEADER_BYTES - 16), 16'h0000);
        put_attr(ATTR_XOR_MAPPED_ADDR, 8, 16'hBEEF);
        repeat (20) dgram_bytes.push_back(8'($urandom));
        send_datagram();
    endtask

    // Mostly well-formed binding responses with random attributes, some cut
    // short, and a share of raw noise.
    task automatic random_datagram();
        int          n;
        bit [15:0]   kind;
        bit [15:0]   len;
        if ($urandom_range(0, 9) < 2)
        begin
            n = $urandom_range(1, 48);
            repeat (n) dgram_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1 && n > 1)
            begin
                dgram_bytes[0] = BIND_RESP_TYPE[15:8];
                dgram_bytes[1] = BIND_RESP_TYPE[7:0];
            end
        end
        else
        begin
            put_header(($urandom_range(0, 9) == 0) ? 16'($urandom) : BIND_RESP_TYPE);
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0, 1:    kind = ATTR_MAPPED_ADDR;
                    2, 3:    kind = ATTR_XOR_MAPPED_ADDR;
                    4:       kind = OTHER_ATTR;
                    default: kind = 16'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0:       len = 16'($urandom_range(0, 3));
                    1:       len = 16'($urandom);
                    default: len = 16'($urandom_range(4, 24));
                endcase
                put_attr(kind, len, 16'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                truncate_to($urandom_range(1, dgram_bytes.size()));
        end
        send_datagram();
    endtask

    // Stimulus and end of run.
    initial
    begin
        int unsigned random_start;
        int          dgrams;
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = '0;
        in_ch.end_of_datagram = 1'b0;
        bytes_sent            = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_datagrams();

        random_start = bytes_sent;
        dgrams       = 0;
        while (bytes_sent - random_start < RANDOM_BYTES || dgrams < RANDOM_DGRAMS)
        begin
            random_datagram();
            dgrams++;
        end
        in_ch.valid <= 1'b0;

        // Drain, then leave a few cycles for any stray result to show up.
        while (port_board.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (port_board.failures == 0 && port_board.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result receiver: stalls a random number of cycles before each item,
    // with calm items, drawn one by one, where ready stays high.
    initial
    begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            snk_calm = ($urandom_range(0, 3) == 0);
            stall    = idle_cycles(snk_calm);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            port_board.check_result(out_ch.status, out_ch.mapped_port);
            @(negedge clk);
        end
    end

    // Run limit, well above the slowest legal run.
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
